>>> src/necir_pkg.sv
// Shared types, codes and reset values for the NEC infrared transmitter.
package necir_pkg;

    localparam int FRAME_BITS_DEF = 32;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [7:0]  HALF_PERIOD_RST  = 8'd13;
    localparam logic [15:0] LEADER_MARK_RST  = 16'd9000;
    localparam logic [15:0] LEADER_SPACE_RST = 16'd4500;
    localparam logic [15:0] BIT_MARK_RST     = 16'd560;
    localparam logic [15:0] ONE_SPACE_RST    = 16'd1690;
    localparam logic [15:0] ZERO_SPACE_RST   = 16'd560;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD_MARK,
        PH_LEAD_SPACE,
        PH_BIT_MARK,
        PH_BIT_SPACE,
        PH_STOP_MARK,
        PH_BURST_MARK
    } phase_t;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_FRAME = 2'd1,
        OP_BURST = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_TICK     = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_DISABLED = 2'd2,
        ST_BUSY     = 2'd3
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ENABLE       = 3'd0,
        CFG_HALF_PERIOD  = 3'd1,
        CFG_LEADER_MARK  = 3'd2,
        CFG_LEADER_SPACE = 3'd3,
        CFG_BIT_MARK     = 3'd4,
        CFG_ONE_SPACE    = 3'd5,
        CFG_ZERO_SPACE   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic        enable;
        logic [7:0]  half_period_ticks;
        logic [15:0] leader_mark_us;
        logic [15:0] leader_space_us;
        logic [15:0] bit_mark_us;
        logic [15:0] one_space_us;
        logic [15:0] zero_space_us;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  address;
        logic [7:0]  command_byte;
        logic [15:0] burst_length;
    } req_t;

    typedef struct packed {
        logic    ir_level;
        logic    busy_res;
        status_t status;
    } rsp_t;

endpackage

>>> src/nec_ir_transmitter.sv
// Top level of the NEC infrared transmitter with a carrier generator.
// The response is registered; the response register loads at the edge that accepts the request.
// Throughput: one request per cycle while the response is not stalled; a tick, or a command
// taken while enabled and idle, updates the segment state registers in the cycle it is accepted.
// A stalled response holds off requests; a new one enters in the cycle the response leaves.
// Reset clears the waveform state to idle with the output low and loads the defaults.
module nec_ir_transmitter
    import necir_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  req_t                   req_data,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output rsp_t                   rsp_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int BW = $clog2(FRAME_BITS + 1);
    localparam int IW = $clog2(FRAME_BITS);

    typedef struct packed {
        phase_t                phase;
        logic [FRAME_BITS-1:0] shift;
        logic [BW-1:0]         bits;
        logic [15:0]           target;
        logic                  carrier;
    } seg_t;

    cfg_t                  cfg_reg, cfg_next;
    phase_t                phase_reg, phase_next;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic [BW-1:0]         bits_reg, bits_next;
    logic [15:0]           target_reg, target_next;
    logic [16:0]           elapsed_reg, elapsed_next;
    logic [7:0]            half_cnt_reg, half_cnt_next;
    logic                  carrier_reg, carrier_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_data_reg, rsp_data_next;

    logic                  req_fire;
    logic                  cmd_ok;
    logic                  load;
    seg_t                  seg;
    seg_t                  done_seg;
    logic [31:0]           frame_word;
    logic [7:0]            half;
    logic [7:0]            half_inc;
    logic [16:0]           mark_sum;
    logic [16:0]           space_sum;

    function automatic seg_t make_seg(phase_t p, logic [FRAME_BITS-1:0] sh, logic [BW-1:0] b,
                                      logic [15:0] t, logic c);
        seg_t s;
        s.phase   = p;
        s.shift   = sh;
        s.bits    = b;
        s.target  = t;
        s.carrier = c;
        return s;
    endfunction

    function automatic seg_t enter_stop(logic [FRAME_BITS-1:0] sh, logic [BW-1:0] b, cfg_t c);
        seg_t s;
        if (c.bit_mark_us != 16'd0)
        begin
            s = make_seg(PH_STOP_MARK, sh, b, c.bit_mark_us, 1'b1);
        end
        else
        begin
            s = make_seg(PH_IDLE, sh, b, 16'd0, 1'b0);
        end
        return s;
    endfunction

    // With a zero bit mark, data bits whose space is also zero are skipped at once.
    function automatic seg_t enter_bits(logic [FRAME_BITS-1:0] sh, logic [BW-1:0] b, cfg_t c);
        seg_t          s;
        logic          found;
        logic [IW-1:0] idx;
        logic          cand;
        found = 1'b0;
        idx   = '0;
        for (int i = FRAME_BITS - 1; i >= 0; i--)
        begin
            cand = (BW'(i) < b) &&
                   (sh[i] ? (c.one_space_us != 16'd0) : (c.zero_space_us != 16'd0));
            if (cand)
            begin
                found = 1'b1;
                idx   = IW'(i);
            end
        end
        if (b == '0)
        begin
            s = enter_stop(sh, b, c);
        end
        else if (c.bit_mark_us != 16'd0)
        begin
            s = make_seg(PH_BIT_MARK, sh, b, c.bit_mark_us, 1'b1);
        end
        else if (found)
        begin
            s = make_seg(PH_BIT_SPACE, sh >> idx, b - BW'(idx),
                         sh[idx] ? c.one_space_us : c.zero_space_us, 1'b0);
        end
        else
        begin
            s = enter_stop(sh, b, c);
        end
        return s;
    endfunction

    function automatic seg_t enter_bit_space(logic [FRAME_BITS-1:0] sh, logic [BW-1:0] b,
                                             cfg_t c);
        seg_t        s;
        logic [15:0] sp;
        sp = sh[0] ? c.one_space_us : c.zero_space_us;
        if (sp != 16'd0)
        begin
            s = make_seg(PH_BIT_SPACE, sh, b, sp, 1'b0);
        end
        else
        begin
            s = enter_bits(sh >> 1, (b != '0) ? b - BW'(1) : b, c);
        end
        return s;
    endfunction

    function automatic seg_t enter_lead_space(logic [FRAME_BITS-1:0] sh, logic [BW-1:0] b,
                                              cfg_t c);
        seg_t s;
        if (c.leader_space_us != 16'd0)
        begin
            s = make_seg(PH_LEAD_SPACE, sh, b, c.leader_space_us, 1'b0);
        end
        else
        begin
            s = enter_bits(sh, BW'(FRAME_BITS), c);
        end
        return s;
    endfunction

    function automatic seg_t enter_lead_mark(logic [FRAME_BITS-1:0] sh, logic [BW-1:0] b,
                                             cfg_t c);
        seg_t s;
        if (c.leader_mark_us != 16'd0)
        begin
            s = make_seg(PH_LEAD_MARK, sh, b, c.leader_mark_us, 1'b1);
        end
        else
        begin
            s = enter_lead_space(sh, b, c);
        end
        return s;
    endfunction

    function automatic logic is_mark(phase_t p);
        return (p == PH_LEAD_MARK) || (p == PH_BIT_MARK) || (p == PH_STOP_MARK) ||
               (p == PH_BURST_MARK);
    endfunction

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    assign cmd_ok     = cfg_reg.enable && (phase_reg == PH_IDLE);
    assign frame_word = {~req_data.command_byte, req_data.command_byte,
                         ~req_data.address, req_data.address};
    assign half       = (cfg_reg.half_period_ticks == 8'd0) ? 8'd1 : cfg_reg.half_period_ticks;
    assign half_inc   = half_cnt_reg + 8'd1;
    assign mark_sum   = elapsed_reg + {8'd0, half, 1'b0};
    assign space_sum  = elapsed_reg + 17'd1;

    always_comb
    begin
        case (phase_reg)
            PH_LEAD_MARK:  done_seg = enter_lead_space(shift_reg, bits_reg, cfg_reg);
            PH_LEAD_SPACE: done_seg = enter_bits(shift_reg, BW'(FRAME_BITS), cfg_reg);
            PH_BIT_MARK:   done_seg = enter_bit_space(shift_reg, bits_reg, cfg_reg);
            PH_BIT_SPACE:  done_seg = enter_bits(shift_reg >> 1,
                                                 (bits_reg != '0) ? bits_reg - BW'(1) : bits_reg,
                                                 cfg_reg);
            default:       done_seg = make_seg(PH_IDLE, shift_reg, bits_reg, 16'd0, 1'b0);
        endcase
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE:       cfg_next.enable            = cfg_data[0];
                CFG_HALF_PERIOD:  cfg_next.half_period_ticks = cfg_data[7:0];
                CFG_LEADER_MARK:  cfg_next.leader_mark_us    = cfg_data;
                CFG_LEADER_SPACE: cfg_next.leader_space_us   = cfg_data;
                CFG_BIT_MARK:     cfg_next.bit_mark_us       = cfg_data;
                CFG_ONE_SPACE:    cfg_next.one_space_us      = cfg_data;
                CFG_ZERO_SPACE:   cfg_next.zero_space_us     = cfg_data;
                default:          ;
            endcase
        end
    end

    // Next state of the waveform sequencer.
    always_comb
    begin
        phase_next    = phase_reg;
        shift_next    = shift_reg;
        bits_next     = bits_reg;
        target_next   = target_reg;
        elapsed_next  = elapsed_reg;
        half_cnt_next = half_cnt_reg;
        carrier_next  = carrier_reg;
        load          = 1'b0;
        seg           = done_seg;
        if (req_fire)
        begin
            case (req_data.operation)
                OP_TICK:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        carrier_next = 1'b0;
                    end
                    else if (is_mark(phase_reg))
                    begin
                        half_cnt_next = half_inc;
                        if (half_inc >= half)
                        begin
                            half_cnt_next = 8'd0;
                            if (carrier_reg)
                            begin
                                carrier_next = 1'b0;
                            end
                            else
                            begin
                                elapsed_next = mark_sum;
                                if (mark_sum >= {1'b0, target_reg})
                                begin
                                    load = 1'b1;
                                end
                                else
                                begin
                                    carrier_next = 1'b1;
                                end
                            end
                        end
                    end
                    else
                    begin
                        elapsed_next = space_sum;
                        if (space_sum >= {1'b0, target_reg})
                        begin
                            load = 1'b1;
                        end
                    end
                end
                OP_FRAME:
                begin
                    if (cmd_ok)
                    begin
                        load = 1'b1;
                        seg  = enter_lead_mark(frame_word[FRAME_BITS-1:0], '0, cfg_reg);
                    end
                end
                OP_BURST:
                begin
                    if (cmd_ok)
                    begin
                        load = 1'b1;
                        if (req_data.burst_length != 16'd0)
                        begin
                            seg = make_seg(PH_BURST_MARK, shift_reg, bits_reg,
                                           req_data.burst_length, 1'b1);
                        end
                        else
                        begin
                            seg = make_seg(PH_IDLE, shift_reg, bits_reg,
                                           req_data.burst_length, 1'b0);
                        end
                    end
                end
                default: ;
            endcase
        end
        if (load)
        begin
            phase_next    = seg.phase;
            shift_next    = seg.shift;
            bits_next     = seg.bits;
            target_next   = seg.target;
            carrier_next  = seg.carrier;
            elapsed_next  = 17'd0;
            half_cnt_next = 8'd0;
        end
    end

    // Response fields.
    always_comb
    begin
        rsp_valid_next         = req_fire || (rsp_valid_reg && !rsp_ready);
        rsp_data_next.ir_level = carrier_next;
        rsp_data_next.busy_res = (phase_next != PH_IDLE);
        rsp_data_next.status   = ST_TICK;
        case (req_data.operation)
            OP_TICK:
            begin
                rsp_data_next.ir_level = carrier_reg;
                rsp_data_next.busy_res = (phase_reg != PH_IDLE);
            end
            OP_FRAME, OP_BURST:
            begin
                if (!cfg_reg.enable)
                begin
                    rsp_data_next.status = ST_DISABLED;
                end
                else if (phase_reg != PH_IDLE)
                begin
                    rsp_data_next.status = ST_BUSY;
                end
                else
                begin
                    rsp_data_next.status = ST_ACCEPTED;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable            <= 1'b0;
            cfg_reg.half_period_ticks <= HALF_PERIOD_RST;
            cfg_reg.leader_mark_us    <= LEADER_MARK_RST;
            cfg_reg.leader_space_us   <= LEADER_SPACE_RST;
            cfg_reg.bit_mark_us       <= BIT_MARK_RST;
            cfg_reg.one_space_us      <= ONE_SPACE_RST;
            cfg_reg.zero_space_us     <= ZERO_SPACE_RST;
            phase_reg                 <= PH_IDLE;
            shift_reg                 <= '0;
            bits_reg                  <= '0;
            target_reg                <= 16'd0;
            elapsed_reg               <= 17'd0;
            half_cnt_reg              <= 8'd0;
            carrier_reg               <= 1'b0;
            rsp_valid_reg             <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            phase_reg     <= phase_next;
            shift_reg     <= shift_next;
            bits_reg      <= bits_next;
            target_reg    <= target_next;
            elapsed_reg   <= elapsed_next;
            half_cnt_reg  <= half_cnt_next;
            carrier_reg   <= carrier_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

endmodule

>>> src/necir_checker.sv
// Port-level assertions for the NEC infrared transmitter and their binding.
module necir_checker
    import necir_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data
);

    // Every accepted request produces a response in the next cycle.
    a_req_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("accepted request produced no response");

    // A stalled response blocks new requests.
    a_stall_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("request accepted while response is stalled");

    // A command rejected as busy must report a transmission in progress.
    a_busy_reject: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status == ST_BUSY) |-> rsp_data.busy_res)
        else $error("busy rejection reported while idle");

    // The LED is never driven while idle.
    a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.busy_res |-> !rsp_data.ir_level)
        else $error("output high while idle");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled response changed");

endmodule

bind nec_ir_transmitter necir_checker u_necir_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);

>>> verif/nec_ir_checker.sv
// Response checker for the NEC infrared transmitter: predicts every response and compares it.
`timescale 1ns / 100ps

module nec_ir_checker
    import necir_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  logic                   req_ready,
    input  req_t                   req_data,
    input  logic                   rsp_valid,
    input  logic                   rsp_ready,
    input  rsp_t                   rsp_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     awaited,
    output int                     responses_seen,
    output int                     commands_taken
);

    localparam int FRAME_LEN = FRAME_BITS_DEF;

    cfg_t        regs;
    phase_t      wave_phase;
    logic [31:0] frame_word;
    logic [5:0]  bits_remaining;
    logic [15:0] segment_length;
    logic [16:0] segment_elapsed;
    logic [7:0]  half_count;
    logic        led_on;
    rsp_t        awaited_responses[$];

    function automatic logic [8:0] half_len();
        return (regs.half_period_ticks == 8'd0) ? 9'd1 : {1'b0, regs.half_period_ticks};
    endfunction

    function automatic logic is_mark(phase_t p);
        return p == PH_LEAD_MARK || p == PH_BIT_MARK || p == PH_STOP_MARK ||
               p == PH_BURST_MARK;
    endfunction

    // Moving past a bit space consumes that data bit.
    function automatic phase_t phase_after(phase_t p);
        phase_t nxt;
        nxt = PH_IDLE;
        case (p)
            PH_LEAD_MARK: nxt = PH_LEAD_SPACE;
            PH_LEAD_SPACE:
            begin
                bits_remaining = 6'(FRAME_LEN & 63);
                nxt = (bits_remaining != 6'd0) ? PH_BIT_MARK : PH_STOP_MARK;
            end
            PH_BIT_MARK: nxt = PH_BIT_SPACE;
            PH_BIT_SPACE:
            begin
                frame_word = frame_word >> 1;
                if (bits_remaining != 6'd0)
                    bits_remaining = bits_remaining - 6'd1;
                nxt = (bits_remaining != 6'd0) ? PH_BIT_MARK : PH_STOP_MARK;
            end
            default: nxt = PH_IDLE;
        endcase
        return nxt;
    endfunction

    // Segments of zero length are passed over without taking any time.
    function automatic void enter_segment(phase_t p);
        phase_t cur;
        logic   settled;
        cur = p;
        settled = 1'b0;
        while (!settled)
        begin
            wave_phase = cur;
            segment_elapsed = '0;
            half_count = '0;
            case (cur)
                PH_IDLE:
                begin
                    led_on = 1'b0;
                    settled = 1'b1;
                end
                PH_LEAD_MARK:  segment_length = regs.leader_mark_us;
                PH_LEAD_SPACE: segment_length = regs.leader_space_us;
                PH_BIT_MARK:   segment_length = regs.bit_mark_us;
                PH_BIT_SPACE:
                    segment_length = frame_word[0] ? regs.one_space_us : regs.zero_space_us;
                PH_STOP_MARK:  segment_length = regs.bit_mark_us;
                default: ;
            endcase
            if (!settled)
            begin
                if (segment_length != 16'd0)
                begin
                    led_on = is_mark(cur);
                    settled = 1'b1;
                end
                else
                    cur = phase_after(cur);
            end
        end
    endfunction

    function automatic void advance_microsecond();
        if (wave_phase == PH_IDLE)
            led_on = 1'b0;
        else if (is_mark(wave_phase))
        begin
            half_count = half_count + 8'd1;
            if ({1'b0, half_count} >= half_len())
            begin
                half_count = '0;
                if (led_on)
                    led_on = 1'b0;
                else
                begin
                    segment_elapsed = segment_elapsed + {7'd0, half_len(), 1'b0};
                    if (segment_elapsed >= {1'b0, segment_length})
                        enter_segment(phase_after(wave_phase));
                    else
                        led_on = 1'b1;
                end
            end
        end
        else
        begin
            segment_elapsed = segment_elapsed + 17'd1;
            if (segment_elapsed >= {1'b0, segment_length})
                enter_segment(phase_after(wave_phase));
        end
    endfunction

    function automatic rsp_t predict_response(req_t r);
        rsp_t    res;
        status_t verdict;
        verdict = ST_TICK;
        if (r.operation == OP_TICK)
        begin
            res.ir_level = led_on;
            res.busy_res = (wave_phase != PH_IDLE);
            res.status = ST_TICK;
            advance_microsecond();
            return res;
        end
        if (r.operation == OP_FRAME || r.operation == OP_BURST)
        begin
            if (!regs.enable)
                verdict = ST_DISABLED;
            else if (wave_phase != PH_IDLE)
                verdict = ST_BUSY;
            else
            begin
                verdict = ST_ACCEPTED;
                if (r.operation == OP_FRAME)
                begin
                    frame_word = {~r.command_byte, r.command_byte, ~r.address, r.address};
                    bits_remaining = '0;
                    enter_segment(PH_LEAD_MARK);
                end
                else
                begin
                    segment_length = r.burst_length;
                    enter_segment(PH_BURST_MARK);
                end
            end
        end
        res.ir_level = led_on;
        res.busy_res = (wave_phase != PH_IDLE);
        res.status = verdict;
        return res;
    endfunction

    task automatic note_mismatch(input logic has_want, input rsp_t want, input rsp_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            if (has_want)
                $display("%0t: response mismatch: expected level %b busy %b status %0d,",
                         $time, want.ir_level, want.busy_res, want.status,
                         " got level %b busy %b status %0d",
                         got.ir_level, got.busy_res, got.status);
            else
                $display("%0t: unexpected response: level %b busy %b status %0d",
                         $time, got.ir_level, got.busy_res, got.status);
        end
    endtask

    always @(posedge clk)
    begin : monitor
        rsp_t want;
        if (!rst_n)
        begin
            regs.enable = 1'b0;
            regs.half_period_ticks = HALF_PERIOD_RST;
            regs.leader_mark_us = LEADER_MARK_RST;
            regs.leader_space_us = LEADER_SPACE_RST;
            regs.bit_mark_us = BIT_MARK_RST;
            regs.one_space_us = ONE_SPACE_RST;
            regs.zero_space_us = ZERO_SPACE_RST;
            wave_phase = PH_IDLE;
            frame_word = '0;
            bits_remaining = '0;
            segment_length = '0;
            segment_elapsed = '0;
            half_count = '0;
            led_on = 1'b0;
            awaited_responses.delete();
            mismatches = 0;
            responses_seen = 0;
            commands_taken = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENABLE:       regs.enable = cfg_data[0];
                    CFG_HALF_PERIOD:  regs.half_period_ticks = cfg_data[7:0];
                    CFG_LEADER_MARK:  regs.leader_mark_us = cfg_data;
                    CFG_LEADER_SPACE: regs.leader_space_us = cfg_data;
                    CFG_BIT_MARK:     regs.bit_mark_us = cfg_data;
                    CFG_ONE_SPACE:    regs.one_space_us = cfg_data;
                    CFG_ZERO_SPACE:   regs.zero_space_us = cfg_data;
                    default: ;
                endcase
            end
            if (req_valid && req_ready)
                awaited_responses.push_back(predict_response(req_data));
            if (rsp_valid && rsp_ready)
            begin
                responses_seen++;
                if (rsp_data.status == ST_ACCEPTED)
                    commands_taken++;
                if (awaited_responses.size() == 0)
                    note_mismatch(1'b0, rsp_data, rsp_data);
                else
                begin
                    want = awaited_responses.pop_front();
                    if (rsp_data.ir_level !== want.ir_level ||
                        rsp_data.busy_res !== want.busy_res ||
                        rsp_data.status !== want.status)
                        note_mismatch(1'b1, want, rsp_data);
                end
            end
        end
        awaited = awaited_responses.size();
    end

endmodule

>>> verif/nec_ir_transmitter_test.sv
// Testbench top for the NEC infrared transmitter: stimulus, configuration and verdict.
`timescale 1ns / 100ps

module nec_ir_transmitter_test;
    import necir_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 800;
    localparam int RANDOM_PHASES = 8;
    localparam int DRAIN_TICKS = 16;
    localparam int DRAIN_LIMIT = 256;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    req_t                   req_data = '0;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b0;
    rsp_t                   rsp_data;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_ENABLE;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int   mismatches;
    int   awaited;
    int   responses_seen;
    int   commands_taken;
    logic idling_on = 1'b1;
    logic last_busy = 1'b0;
    int   quiet_cycles = 0;
    int   ticks_sent = 0;
    int   frames_sent = 0;
    int   bursts_sent = 0;
    int   unused_sent = 0;
    int   settings_used = 0;

    nec_ir_transmitter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nec_ir_checker response_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_data       (req_data),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp_data       (rsp_data),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .awaited        (awaited),
        .responses_seen (responses_seen),
        .commands_taken (commands_taken)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin : rsp_stalls
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                rsp_ready <= 1'b0;
            end
            else if (idling_on && rst_n && $urandom_range(0, 9) == 0)
            begin
                hold = $urandom_range(1, 13) - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
            last_busy <= rsp_data.busy_res;
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: nothing moved for %0d cycles.", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic req_t make_req(input logic [1:0] op, input logic [7:0] addr,
                                      input logic [7:0] cmd, input logic [15:0] len);
        req_t r;
        r.operation = op;
        r.address = addr;
        r.command_byte = cmd;
        r.burst_length = len;
        return r;
    endfunction

    task automatic send_request(input req_t r);
        if (idling_on && $urandom_range(0, 11) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (r.operation == OP_TICK)
            ticks_sent++;
        else if (r.operation == OP_FRAME)
            frames_sent++;
        else if (r.operation == OP_BURST)
            bursts_sent++;
        else
            unused_sent++;
    endtask

    task automatic run_ticks(input int n);
        repeat (n) send_request(make_req(OP_TICK, 8'($urandom), 8'($urandom), 16'($urandom)));
    endtask

    task automatic wait_responses();
        req_valid <= 1'b0;
        @(negedge clk);
        while (awaited != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic drain_waveform();
        int rounds;
        rounds = 0;
        do
        begin
            if (rounds >= DRAIN_LIMIT)
            begin
                $display("Waveform still busy after %0d ticks.", DRAIN_LIMIT * DRAIN_TICKS);
                $display("TEST FAILED");
                $finish;
            end
            rounds++;
            run_ticks(DRAIN_TICKS);
            wait_responses();
        end
        while (last_busy);
    endtask

    task automatic quiesce();
        wait_responses();
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_enable(input logic on);
        quiesce();
        write_reg(CFG_ENABLE, {15'd0, on});
    endtask

    task automatic load_timing(input logic [7:0] half, input logic [15:0] lead_mark,
                               input logic [15:0] lead_space, input logic [15:0] bit_mark,
                               input logic [15:0] one_space, input logic [15:0] zero_space);
        quiesce();
        write_reg(CFG_HALF_PERIOD, {8'd0, half});
        write_reg(CFG_LEADER_MARK, lead_mark);
        write_reg(CFG_LEADER_SPACE, lead_space);
        write_reg(CFG_BIT_MARK, bit_mark);
        write_reg(CFG_ONE_SPACE, one_space);
        write_reg(CFG_ZERO_SPACE, zero_space);
        settings_used++;
    endtask

    initial
    begin : stimulus
        int phase_items;
        int pick;
        int n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Commands are refused while the transmitter is disabled.
        send_request(make_req(OP_FRAME, 8'hFF, 8'h00, 16'h0000));
        send_request(make_req(OP_BURST, 8'h00, 8'hFF, 16'hFFFF));
        send_request(make_req(OP_UNUSED, 8'hFF, 8'hFF, 16'hFFFF));
        send_request(make_req(OP_TICK, 8'h00, 8'h00, 16'h0000));
        set_enable(1'b1);

        // A zero-length burst is accepted but leaves the output idle.
        send_request(make_req(OP_BURST, 8'h5A, 8'hC3, 16'h0000));
        send_request(make_req(OP_TICK, 8'hFF, 8'hFF, 16'hFFFF));

        // A short burst at the reset carrier period, with a busy rejection on top.
        send_request(make_req(OP_BURST, 8'h00, 8'hFF, 16'd60));
        send_request(make_req(OP_FRAME, 8'h00, 8'h00, 16'h1234));
        send_request(make_req(OP_UNUSED, 8'h00, 8'h00, 16'h0000));
        drain_waveform();

        // Clearing enable in the middle of a frame lets the frame finish.
        load_timing(8'd1, 16'd3, 16'd3, 16'd2, 16'd3, 16'd1);
        send_request(make_req(OP_FRAME, 8'hA5, 8'h3C, 16'h0000));
        run_ticks(20);
        set_enable(1'b0);
        send_request(make_req(OP_FRAME, 8'h11, 8'h22, 16'h0000));
        drain_waveform();
        set_enable(1'b1);

        // A half period of zero behaves as one tick.
        load_timing(8'd0, 16'd5, 16'd2, 16'd1, 16'd2, 16'd1);
        send_request(make_req(OP_BURST, 8'h00, 8'h00, 16'd5));
        send_request(make_req(OP_FRAME, 8'h80, 8'h01, 16'h0000));
        drain_waveform();
        send_request(make_req(OP_FRAME, 8'h7E, 8'h81, 16'h0000));
        drain_waveform();

        // With every segment at zero the frame is over as soon as it starts.
        load_timing(8'd7, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_request(make_req(OP_FRAME, 8'h3C, 8'hA5, 16'h0000));
        send_request(make_req(OP_TICK, 8'h00, 8'h00, 16'h0000));

        // Longest carrier period with the shortest burst, and a frame refused as busy behind it.
        load_timing(8'd255, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(make_req(OP_BURST, 8'h00, 8'h00, 16'd1));
        send_request(make_req(OP_FRAME, 8'hFF, 8'hFF, 16'h0000));
        drain_waveform();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == RANDOM_PHASES - 1)
                idling_on <= 1'b0;
            load_timing(8'($urandom_range(1, 3)), 16'($urandom_range(0, 6)),
                        16'($urandom_range(1, 6)), 16'($urandom_range(0, 4)),
                        16'($urandom_range(0, 5)), 16'($urandom_range(0, 3)));
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / RANDOM_PHASES)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    n = $urandom_range(1, 20);
                    run_ticks(n);
                    phase_items += n;
                end
                else if (pick < 70)
                begin
                    send_request(make_req(OP_FRAME, 8'($urandom), 8'($urandom), 16'($urandom)));
                    phase_items++;
                end
                else if (pick < 82)
                begin
                    send_request(make_req(OP_BURST, 8'($urandom), 8'($urandom),
                                          16'($urandom_range(0, 24))));
                    phase_items++;
                end
                else if (pick < 90)
                begin
                    // The frame keeps the block busy, so the long burst is refused.
                    send_request(make_req(OP_FRAME, 8'($urandom), 8'($urandom), 16'($urandom)));
                    send_request(make_req(OP_BURST, 8'($urandom), 8'($urandom), 16'($urandom)));
                    phase_items += 2;
                end
                else if (pick < 95)
                begin
                    send_request(make_req(OP_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom)));
                    phase_items++;
                end
                else if (pick < 98)
                    wait_responses();
                else
                begin
                    set_enable(1'b0);
                    send_request(make_req(OP_BURST, 8'($urandom), 8'($urandom), 16'($urandom)));
                    set_enable(1'b1);
                    phase_items++;
                end
            end
            drain_waveform();
        end

        wait_responses();
        repeat (10) @(posedge clk);
        @(negedge clk);
        $display("Sent %0d ticks, %0d frame and %0d burst commands, %0d unused-code requests",
                 ticks_sent, frames_sent, bursts_sent, unused_sent);
        $display("over %0d timing settings; %0d responses compared, %0d commands accepted.",
                 settings_used, responses_seen, commands_taken);
        if (mismatches == 0 && awaited == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches, %0d responses never arrived.", mismatches, awaited);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
